[src/sh32_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and round functions of the Shadow-32 encryption unit.
// No dependencies; used by shadow32_encryption_unit.
package sh32_pkg;

   localparam int ROUND_COUNT = 16;

   // Key bit i sits at index i, so index 0 is the master key MSB.
   typedef logic [0:63] key_type;

   // Four round subkeys: [0] and [1] for the first half-round, [2] and [3] for the second.
   typedef logic [3:0][7:0] subkey_type;

   typedef struct packed {
      logic [7:0] la;
      logic [7:0] ra;
      logic [7:0] lb;
      logic [7:0] rb;
   } block_type;

   localparam logic [5:0] KEY_PERM [64] = '{
      6'd56, 6'd57, 6'd58, 6'd59, 6'd16, 6'd17, 6'd18, 6'd19,
      6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27,
      6'd60, 6'd61, 6'd62, 6'd63, 6'd28, 6'd29, 6'd30, 6'd31,
      6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39,
      6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47,
      6'd48, 6'd49, 6'd50, 6'd51, 6'd52, 6'd53, 6'd54, 6'd55,
      6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,
      6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15
   };

   // Bit positions of each subkey, MSB first.
   localparam logic [5:0] SUB_POS [4][8] = '{
      '{6'd0,  6'd1,  6'd2,  6'd3,  6'd8,  6'd9,  6'd10, 6'd11},
      '{6'd4,  6'd5,  6'd6,  6'd7,  6'd12, 6'd13, 6'd14, 6'd15},
      '{6'd16, 6'd17, 6'd18, 6'd19, 6'd24, 6'd25, 6'd26, 6'd27},
      '{6'd20, 6'd21, 6'd22, 6'd23, 6'd28, 6'd29, 6'd30, 6'd31}
   };

   function automatic logic [7:0] mix(input logic [7:0] x);
      logic [7:0] r1;
      logic [7:0] r2;
      logic [7:0] r7;
      r1 = {x[6:0], x[7]};
      r2 = {x[5:0], x[7:6]};
      r7 = {x[0], x[7:1]};
      return (r1 & r7) ^ r2;
   endfunction

   // NX step on bits 56..63, then the bit permutation. Terms kept as specified,
   // including the self-cancelling ones.
   function automatic key_type key_step(input key_type a);
      key_type n;
      key_type k;
      n = a;
      n[56] = a[56] & (a[56] ^ a[62]);
      n[57] = a[57] & (a[57] ^ a[63]);
      n[58] = a[58] & (a[58] ^ a[56] ^ a[62]);
      n[59] = a[59] & (a[59] ^ a[57] ^ a[63]);
      n[60] = a[60] & (a[60] ^ a[58] ^ a[56] ^ a[62]);
      n[61] = a[61] & (a[61] ^ a[59] ^ a[57] ^ a[63]);
      n[62] = a[62] & (a[62] ^ a[60] ^ a[58] ^ a[56] ^ a[62]);
      n[63] = a[63] & (a[63] ^ a[61] ^ a[59] ^ a[57] ^ a[63]);
      for (int i = 0; i < 64; i++) begin
         k[i] = n[KEY_PERM[i]];
      end
      return k;
   endfunction

   function automatic subkey_type extract_subkeys(input key_type k);
      subkey_type s;
      for (int j = 0; j < 4; j++) begin
         for (int i = 0; i < 8; i++) begin
            s[j][7-i] = k[SUB_POS[j][i]];
         end
      end
      return s;
   endfunction

   function automatic block_type cipher_round(input block_type b, input subkey_type sk);
      block_type o;
      logic [7:0] na;
      logic [7:0] nb;
      na   = mix(b.la) ^ b.ra ^ sk[0];
      nb   = mix(b.lb) ^ b.rb ^ sk[1];
      // left bytes swap at the end of the round
      o.la = nb;
      o.ra = mix(na) ^ b.la ^ sk[2];
      o.lb = na;
      o.rb = mix(nb) ^ b.lb ^ sk[3];
      return o;
   endfunction

endpackage

[src/shadow32_encryption_unit.sv]
`timescale 1ns / 1ps
// Shadow-32 encryption unit: input register, 16 unrolled rounds, result register.
// Depends on sh32_pkg.
//
//  port group  direction  handshake            payload
//  req_*       in         req_valid/req_stall  four plaintext bytes
//  rsp_*       out        rsp_valid/rsp_stall  four ciphertext bytes
//  csr_*       in         csr_we               64-bit master key
//
// One block per cycle while rsp_stall is low; each block is registered in the input
// register and then in the result register, around the round logic.
// Round keys are expanded at key write and held in registers, so the key is
// usable on the cycle after the write. Reset (synchronous) empties both stages
// and loads the round keys of an all-zero master key. A stalled result holds
// both stages; req_stall rises only when the input stage cannot move on.
module shadow32_encryption_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_left_a_in,
   input  logic [7:0]  req_right_a_in,
   input  logic [7:0]  req_left_b_in,
   input  logic [7:0]  req_right_b_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_left_a_out,
   output logic [7:0]  rsp_right_a_out,
   output logic [7:0]  rsp_left_b_out,
   output logic [7:0]  rsp_right_b_out,
   input  logic        csr_we,
   input  logic [63:0] csr_wdata
);

   sh32_pkg::subkey_type rk_ff [sh32_pkg::ROUND_COUNT];
   sh32_pkg::subkey_type rk_in [sh32_pkg::ROUND_COUNT];
   sh32_pkg::key_type    kchain [sh32_pkg::ROUND_COUNT+1];

   logic                 s1_valid_ff;
   sh32_pkg::block_type  s1_data_ff;
   logic                 out_valid_ff;
   sh32_pkg::block_type  out_data_ff;
   sh32_pkg::block_type  out_data_in;
   sh32_pkg::block_type  st [sh32_pkg::ROUND_COUNT+1];

   logic out_free;
   logic s1_move;
   logic s1_load;

   // key schedule from the write data
   always_comb begin
      kchain[0] = csr_wdata;
      for (int r = 0; r < sh32_pkg::ROUND_COUNT; r++) begin
         kchain[r+1] = sh32_pkg::key_step(kchain[r]);
         rk_in[r]    = sh32_pkg::extract_subkeys(kchain[r+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < sh32_pkg::ROUND_COUNT; r++) begin
            rk_ff[r] <= '0;
         end
      end else if (csr_we) begin
         rk_ff <= rk_in;
      end
   end

   // rounds
   always_comb begin
      st[0] = s1_data_ff;
      for (int r = 0; r < sh32_pkg::ROUND_COUNT; r++) begin
         st[r+1] = sh32_pkg::cipher_round(st[r], rk_ff[r]);
      end
      out_data_in = st[sh32_pkg::ROUND_COUNT];
   end

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign s1_load   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_data_ff.la <= req_left_a_in;
         s1_data_ff.ra <= req_right_a_in;
         s1_data_ff.lb <= req_left_b_in;
         s1_data_ff.rb <= req_right_b_in;
      end
      if (s1_move) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_left_a_out  = out_data_ff.la;
   assign rsp_right_a_out = out_data_ff.ra;
   assign rsp_left_b_out  = out_data_ff.lb;
   assign rsp_right_b_out = out_data_ff.rb;

endmodule

[bench/shadow32_encryption_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for shadow32_encryption_unit: queued plaintext blocks, random gaps
// and stalls on both channels, ciphertext checked against an in-bench cipher model.
// Depends on the DUT (and through it sh32_pkg) only.
module shadow32_encryption_unit_tb;

   localparam int ROUNDS       = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int BLOCKS_PER_PHASE = 250;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [7:0] la;
      logic [7:0] ra;
      logic [7:0] lb;
      logic [7:0] rb;
   } quad_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_left_a_in = 8'h00;
   logic [7:0]  req_right_a_in = 8'h00;
   logic [7:0]  req_left_b_in = 8'h00;
   logic [7:0]  req_right_b_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_left_a_out;
   logic [7:0]  rsp_right_a_out;
   logic [7:0]  rsp_left_b_out;
   logic [7:0]  rsp_right_b_out;
   logic        csr_we = 1'b0;
   logic [63:0] csr_wdata = 64'h0;

   quad_t       plain_pending[$];
   quad_t       cipher_expected[$];
   logic [63:0] master_key = 64'h0;
   bit          sender_idles = 1'b0;
   bit          receiver_idles = 1'b0;
   int          fail_count = 0;
   int          blocks_out = 0;
   int          cycles = 0;

   shadow32_encryption_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_left_a_in   (req_left_a_in),
      .req_right_a_in  (req_right_a_in),
      .req_left_b_in   (req_left_b_in),
      .req_right_b_in  (req_right_b_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_a_out  (rsp_left_a_out),
      .rsp_right_a_out (rsp_right_a_out),
      .rsp_left_b_out  (rsp_left_b_out),
      .rsp_right_b_out (rsp_right_b_out),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // F(x) = (rol1 & rol7) ^ rol2 on bytes
   function automatic logic [7:0] round_mix(input logic [7:0] x);
      logic [7:0] r1;
      logic [7:0] r2;
      logic [7:0] r7;
      r1 = (x << 1) | (x >> 7);
      r2 = (x << 2) | (x >> 6);
      r7 = (x << 7) | (x >> 1);
      return (r1 & r7) ^ r2;
   endfunction

   function automatic quad_t shadow_encrypt(input logic [63:0] mk, input quad_t p);
      logic [0:63] kb;
      logic [0:63] nx;
      logic [7:0]  k0, k1, k2, k3;
      logic [7:0]  la, ra, lb, rb, na, nb;
      quad_t       c;
      kb = mk;   // index 0 takes the key MSB
      la = p.la;
      ra = p.ra;
      lb = p.lb;
      rb = p.rb;
      for (int r = 0; r < ROUNDS; r++) begin
         nx = kb;
         nx[56] = kb[56] & (kb[56] ^ kb[62]);
         nx[57] = kb[57] & (kb[57] ^ kb[63]);
         nx[58] = kb[58] & (kb[58] ^ kb[56] ^ kb[62]);
         nx[59] = kb[59] & (kb[59] ^ kb[57] ^ kb[63]);
         nx[60] = kb[60] & (kb[60] ^ kb[58] ^ kb[56] ^ kb[62]);
         nx[61] = kb[61] & (kb[61] ^ kb[59] ^ kb[57] ^ kb[63]);
         nx[62] = kb[62] & (kb[62] ^ kb[60] ^ kb[58] ^ kb[56] ^ kb[62]);
         nx[63] = kb[63] & (kb[63] ^ kb[61] ^ kb[59] ^ kb[57] ^ kb[63]);
         kb = {nx[56:59], nx[16:27], nx[60:63], nx[28:55], nx[0:15]};
         k0 = {kb[0:3],   kb[8:11]};
         k1 = {kb[4:7],   kb[12:15]};
         k2 = {kb[16:19], kb[24:27]};
         k3 = {kb[20:23], kb[28:31]};
         na = round_mix(la) ^ ra ^ k0;
         nb = round_mix(lb) ^ rb ^ k1;
         ra = round_mix(na) ^ la ^ k2;
         rb = round_mix(nb) ^ lb ^ k3;
         la = nb;
         lb = na;
      end
      c.la = la;
      c.ra = ra;
      c.lb = lb;
      c.rb = rb;
      return c;
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic queue_block(input logic [31:0] v);
      plain_pending.push_back(quad_t'(v));
   endtask

   // settles with #1 so every edge update is visible
   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (plain_pending.size() != 0 || req_valid || cipher_expected.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_key(input logic [63:0] k);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= k;
      @(posedge clock);
      csr_we    <= 1'b0;
      master_key = k;
      #1;
   endtask

   task automatic queue_directed();
      queue_block(32'h00000000);
      queue_block(32'hFFFFFFFF);
      queue_block(32'hFF000000);
      queue_block(32'h00FF0000);
      queue_block(32'h0000FF00);
      queue_block(32'h000000FF);
      queue_block(32'h80808080);
      queue_block(32'h01010101);
      queue_block(32'hAA55AA55);
      queue_block(32'h55AA55AA);
      queue_block(32'h7F7F7F7F);
      queue_block(32'hFEFEFEFE);
   endtask

   // driver: one new block per free slot, with a random per-block gap while sender_idles is set
   int gap_left = 0;
   always @(posedge clock) begin
      quad_t nxt;
      logic  nv;
      nv = req_valid;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            cipher_expected.push_back(shadow_encrypt(master_key,
               {req_left_a_in, req_right_a_in, req_left_b_in, req_right_b_in}));
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               nv = 1'b0;
            end else if (plain_pending.size() != 0) begin
               nxt = plain_pending.pop_front();
               req_left_a_in  <= nxt.la;
               req_right_a_in <= nxt.ra;
               req_left_b_in  <= nxt.lb;
               req_right_b_in <= nxt.rb;
               nv = 1'b1;
               gap_left = sender_idles ? $urandom_range(0, 3) : 0;
            end else begin
               nv = 1'b0;
            end
         end
      end
      req_valid <= nv;
   end

   // monitor: checks each result transfer, draws stalls, and holds off twice for long
   int stall_left = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      quad_t got;
      quad_t exp_q;
      logic  ns;
      ns = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_left_a_out, rsp_right_a_out, rsp_left_b_out, rsp_right_b_out};
            if (cipher_expected.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("unexpected result %h at cycle %0d", got, cycles);
            end else begin
               exp_q = cipher_expected.pop_front();
               if (got.la !== exp_q.la || got.ra !== exp_q.ra ||
                   got.lb !== exp_q.lb || got.rb !== exp_q.rb) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("mismatch: exp la=%h ra=%h lb=%h rb=%h got la=%h ra=%h lb=%h rb=%h",
                              exp_q.la, exp_q.ra, exp_q.lb, exp_q.rb,
                              got.la, got.ra, got.lb, got.rb);
               end
            end
            blocks_out++;
            if (blocks_out == 300 || blocks_out == 1200)
               hold_left = 150;
            stall_left = receiver_idles ? $urandom_range(0, 3) : 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            ns = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            ns = 1'b1;
         end
      end
      rsp_stall <= ns;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      logic [63:0] phase_key;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      // reset key of zero, then all ones
      queue_directed();
      wait_drained();
      load_key(64'hFFFFFFFF_FFFFFFFF);
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      queue_directed();
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: phase_key = 64'h00000000_00000001;
            1: phase_key = 64'h80000000_00000000;
            2: phase_key = 64'h00000000_000000FF;
            3: phase_key = 64'hFF000000_00000000;
            7: phase_key = 64'h0;
            default: phase_key = {$urandom, $urandom};
         endcase
         load_key(phase_key);
         sender_idles   = p[0];
         receiver_idles = p[1];
         for (int n = 0; n < BLOCKS_PER_PHASE; n++)
            queue_block({pick_byte(), pick_byte(), pick_byte(), pick_byte()});
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0 && cipher_expected.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
